// File: sv/speech_mouth_pixel_overlay_macros.svh
// Assertion macros shared by the mouth overlay modules
`ifndef SPEECH_MOUTH_PIXEL_OVERLAY_MACROS_SVH
`define SPEECH_MOUTH_PIXEL_OVERLAY_MACROS_SVH
`ifndef SYNTH
// check a property at every clock edge outside reset
`define SMPO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("smpo check failed");
// check that a condition holds in the cycle after a trigger
`define SMPO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smpo check failed");
`else
`define SMPO_ASSERT(lbl, prop)
`define SMPO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/smpo_pkg.sv
// Types, constants and arc shape tables of the mouth overlay
package smpo_pkg;

  localparam int POSE_COUNT  = 5;
  localparam int COORD_BITS  = 10;
  localparam int SHAPE_COUNT = 5;
  localparam int ADX_SPAN    = 19;
  localparam int QDEPTH      = 4;

  localparam logic [3:0]  POSE_MAX         = 4'(POSE_COUNT - 1);
  localparam logic [3:0]  SHAPE_MAX        = 4'(SHAPE_COUNT - 1);
  localparam logic [47:0] STEP_INTERVAL_US = 48'd40000;
  localparam logic [47:0] SILENCE_DELAY_US = 48'd200000;
  localparam logic [7:0]  BRIGHT_MIN       = 8'd20;
  localparam logic [4:0]  ADX_LAST         = 5'(ADX_SPAN - 1);

  typedef enum logic [1:0] {
    ACT_PIXEL  = 2'd0,
    ACT_LEVEL  = 2'd1,
    ACT_ACTIVE = 2'd2,
    ACT_FRAME  = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    REG_LEFT     = 3'd0,
    REG_TOP      = 3'd1,
    REG_RIGHT    = 3'd2,
    REG_BOTTOM   = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5,
    REG_BLACK    = 3'd6,
    REG_WHITE    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]            action;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [15:0]           pixel_in;
    logic [7:0]            level;
    logic                  active_flag;
    logic [47:0]           now_us;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic [3:0]  shown_pose;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  mouth_left;
    logic [9:0]  mouth_top;
    logic [10:0] mouth_right;
    logic [10:0] mouth_bottom;
    logic [9:0]  mouth_center_x;
    logic [9:0]  mouth_center_y;
    logic [15:0] black_color;
    logic [15:0] white_color;
  } cfg_t;

  // register set after reset: everything zero but the arc colour
  localparam cfg_t CFG_RESET = '{
    mouth_left:     10'd0,
    mouth_top:      10'd0,
    mouth_right:    11'd0,
    mouth_bottom:   11'd0,
    mouth_center_x: 10'd0,
    mouth_center_y: 10'd0,
    black_color:    16'h0000,
    white_color:    16'hFFFF
  };

  // one classified item between front and back
  typedef struct packed {
    logic                  compose;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [15:0]           pixel_in;
    logic [3:0]            pose;
  } work_t;

  // floor(depth * dx * dx / (half width squared)) per shape and |dx|
  localparam logic [3:0] ARC_DROP [0:SHAPE_COUNT-1][0:ADX_SPAN-1] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd2, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2,
      4'd3, 4'd3, 4'd4, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2,
      4'd3, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
      4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9}
  };

  function automatic logic [2:0] shape_of(input logic [3:0] pose);
    return (pose > SHAPE_MAX) ? SHAPE_MAX[2:0] : pose[2:0];
  endfunction

  function automatic logic [4:0] arc_half(input logic [2:0] s);
    logic [4:0] r;
    case (s)
      3'd0:    r = 5'd10;
      3'd1:    r = 5'd12;
      3'd2:    r = 5'd14;
      3'd3:    r = 5'd16;
      default: r = 5'd18;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] arc_depth(input logic [2:0] s);
    logic [3:0] r;
    case (s)
      3'd0:    r = 4'd2;
      3'd1:    r = 4'd3;
      3'd2:    r = 4'd5;
      3'd3:    r = 4'd7;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] arc_thick(input logic [2:0] s);
    logic [2:0] r;
    case (s)
      3'd0:    r = 3'd2;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd3;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] arc_drop(input logic [2:0] s, input logic [4:0] adx);
    logic [3:0] r;
    if (adx > ADX_LAST || s > SHAPE_MAX[2:0]) begin
      r = 4'd0;
    end else begin
      r = ARC_DROP[s][adx];
    end
    return r;
  endfunction

endpackage

// File: sv/smpo_fifo.sv
// Short queue of classified items between front and back
`include "speech_mouth_pixel_overlay_macros.svh"
module smpo_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  smpo_pkg::work_t push_item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output smpo_pkg::work_t head_o
);
  import smpo_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  work_t              mem_q [QDEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  `SMPO_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(QDEPTH))
  `SMPO_ASSERT_NEXT(a_push_counts, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

// File: sv/smpo_front.sv
// Front end: accept items, run the pose and timing state, classify pixels
`include "speech_mouth_pixel_overlay_macros.svh"
module smpo_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  smpo_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               push_o,
  output smpo_pkg::work_t    push_item_o
);
  import smpo_pkg::*;

  logic        active_q, active_d;
  logic [3:0]  target_q, target_d;
  logic [3:0]  render_q, render_d;
  logic [47:0] voice_t_q, voice_t_d;
  logic [47:0] step_t_q, step_t_d;
  logic        accept;
  logic [3:0]  req_pose;
  logic [47:0] voice_gap, step_gap;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;
  assign voice_gap  = in_item_i.now_us - voice_t_q;
  assign step_gap   = in_item_i.now_us - step_t_q;
  assign req_pose   = (in_item_i.level > {4'd0, POSE_MAX}) ? POSE_MAX : in_item_i.level[3:0];

  always_comb begin
    active_d  = active_q;
    target_d  = target_q;
    render_d  = render_q;
    voice_t_d = voice_t_q;
    step_t_d  = step_t_q;
    if (accept) begin
      case (in_item_i.action)
        ACT_PIXEL: begin
        end
        ACT_LEVEL: begin
          if (active_q) begin
            if (req_pose != 4'd0) begin
              voice_t_d = in_item_i.now_us;
              target_d  = req_pose;
            end else if (voice_gap >= SILENCE_DELAY_US) begin
              target_d = 4'd0;
            end
          end
        end
        ACT_ACTIVE: begin
          active_d  = in_item_i.active_flag;
          target_d  = 4'd0;
          render_d  = 4'd0;
          voice_t_d = in_item_i.active_flag ? in_item_i.now_us : 48'd0;
          step_t_d  = in_item_i.active_flag ? in_item_i.now_us : 48'd0;
        end
        ACT_FRAME: begin
          if (active_q && step_gap >= STEP_INTERVAL_US) begin
            if (render_q < target_q) begin
              render_d = render_q + 4'd1;
            end else if (render_q > target_q) begin
              render_d = render_q - 4'd1;
            end
            step_t_d = in_item_i.now_us;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // the queued item carries the pose as it stands after this item
  always_comb begin
    push_item_o.compose  = active_q && (in_item_i.action == ACT_PIXEL);
    push_item_o.pixel_x  = in_item_i.pixel_x;
    push_item_o.pixel_y  = in_item_i.pixel_y;
    push_item_o.pixel_in = in_item_i.pixel_in;
    push_item_o.pose     = render_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      target_q  <= 4'd0;
      render_q  <= 4'd0;
      voice_t_q <= 48'd0;
      step_t_q  <= 48'd0;
    end else begin
      active_q  <= active_d;
      target_q  <= target_d;
      render_q  <= render_d;
      voice_t_q <= voice_t_d;
      step_t_q  <= step_t_d;
    end
  end

  `SMPO_ASSERT(a_pose_bound, render_q <= POSE_MAX && target_q <= POSE_MAX)
  `SMPO_ASSERT_NEXT(a_step_one, accept && in_item_i.action != ACT_ACTIVE, (render_q == $past(render_q)) || (render_q == $past(render_q) + 4'd1) || (render_q == $past(render_q) - 4'd1))

endmodule

// File: sv/smpo_back.sv
// Back end: two-stage pixel composer with output register
`include "speech_mouth_pixel_overlay_macros.svh"
module smpo_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smpo_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  smpo_pkg::work_t     q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smpo_pkg::out_item_t out_item_o
);
  import smpo_pkg::*;

  logic        adv;
  // stage A
  logic        a_valid_q;
  logic        a_erase_q, a_erase_d;
  logic        a_arc_q, a_arc_d;
  logic [4:0]  a_adx_q;
  logic [2:0]  a_shape_q, a_shape_d;
  logic [9:0]  a_y_q;
  logic [15:0] a_pix_q;
  logic [3:0]  a_pose_q;
  // stage A helpers
  logic        in_rect, bright;
  logic [7:0]  weight;
  logic [10:0] adx;
  // stage B helpers
  logic [10:0] base, y_ext, off;
  logic        on_arc;
  out_item_t   out_q, out_d;
  logic        out_valid_q;

  assign adv         = !out_valid_q || !out_stall_i;
  assign q_pop_o     = adv && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // stage A: rectangle, brightness and arc span
  always_comb begin
    in_rect = (q_head_i.pixel_x >= cfg_i.mouth_left)
           && ({1'b0, q_head_i.pixel_x} < cfg_i.mouth_right)
           && (q_head_i.pixel_y >= cfg_i.mouth_top)
           && ({1'b0, q_head_i.pixel_y} < cfg_i.mouth_bottom);
    weight  = {2'b0, q_head_i.pixel_in[15:11], 1'b0}
            + {2'b0, q_head_i.pixel_in[10:5]}
            + {2'b0, q_head_i.pixel_in[4:0], 1'b0};
    bright  = (weight >= BRIGHT_MIN);
    if (q_head_i.pixel_x < cfg_i.mouth_center_x) begin
      adx = {1'b0, cfg_i.mouth_center_x} - {1'b0, q_head_i.pixel_x};
    end else begin
      adx = {1'b0, q_head_i.pixel_x} - {1'b0, cfg_i.mouth_center_x};
    end
    a_shape_d = shape_of(q_head_i.pose);
    a_erase_d = q_head_i.compose && in_rect && bright;
    a_arc_d   = q_head_i.compose && (adx <= {6'd0, arc_half(a_shape_d)});
  end

  // stage B: arc row test and final colour select
  always_comb begin
    base   = {1'b0, cfg_i.mouth_center_y} + {7'd0, arc_depth(a_shape_q)}
           - {7'd0, arc_drop(a_shape_q, a_adx_q)};
    y_ext  = {1'b0, a_y_q};
    off    = y_ext - base;
    on_arc = a_arc_q && (y_ext >= base) && (off < {8'd0, arc_thick(a_shape_q)});
    out_d.shown_pose = a_pose_q;
    if (on_arc) begin
      out_d.pixel_out = cfg_i.white_color;
    end else if (a_erase_q) begin
      out_d.pixel_out = cfg_i.black_color;
    end else begin
      out_d.pixel_out = a_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= q_valid_i;
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_erase_q <= a_erase_d;
      a_arc_q   <= a_arc_d;
      a_adx_q   <= adx[4:0];
      a_shape_q <= a_shape_d;
      a_y_q     <= q_head_i.pixel_y;
      a_pix_q   <= q_head_i.pixel_in;
      a_pose_q  <= q_head_i.pose;
      out_q     <= out_d;
    end
  end

  `SMPO_ASSERT_NEXT(a_pass_through, adv && a_valid_q && !a_arc_q && !a_erase_q, out_q.pixel_out == $past(a_pix_q))
  `SMPO_ASSERT_NEXT(a_pose_carried, adv && a_valid_q, out_q.shown_pose == $past(a_pose_q))

endmodule

// File: sv/speech_mouth_pixel_overlay.sv
// Top level of the speech mouth overlay on an RGB565 pixel stream
//
//  channel  direction  handshake                payload
//  -------  ---------  -----------------------  ------------------------------
//  in       input      in_valid_i / in_stall_o  in_item_i  (smpo_pkg::in_item_t)
//  out      output     out_valid_o / out_stall_i out_item_o (smpo_pkg::out_item_t)
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One transfer in gives exactly one transfer out. The front takes one item per
// cycle while the four-entry queue has room; the back composes one pixel per
// cycle through two register stages while the output is not stalled, so an item
// passes the queue, stage A and the output register on its way out. Reset is
// asynchronous and active low; it clears the pose and timing state, the queue
// and the pipeline valid bits. A stall on the output freezes the back stages
// and, once the queue fills, raises in_stall_o.
module speech_mouth_pixel_overlay (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smpo_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smpo_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import smpo_pkg::*;

  cfg_t  cfg_q;
  logic  push, q_full, q_valid, q_pop;
  work_t push_item, q_head;

  // Configuration registers; the user must write them only while the block is
  // idle (not enforced by the block), so the back stages may read them directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEFT:     cfg_q.mouth_left     <= cfg_data_i[9:0];
        REG_TOP:      cfg_q.mouth_top      <= cfg_data_i[9:0];
        REG_RIGHT:    cfg_q.mouth_right    <= cfg_data_i[10:0];
        REG_BOTTOM:   cfg_q.mouth_bottom   <= cfg_data_i[10:0];
        REG_CENTER_X: cfg_q.mouth_center_x <= cfg_data_i[9:0];
        REG_CENTER_Y: cfg_q.mouth_center_y <= cfg_data_i[9:0];
        REG_BLACK:    cfg_q.black_color    <= cfg_data_i;
        REG_WHITE:    cfg_q.white_color    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front: advance the pose state and tag each item with the pose to show.
  smpo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // Queue: hold classified items while the output side stalls.
  smpo_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Back: erase bright mouth pixels and draw the arc for the tagged pose.
  smpo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/tb_speech_mouth_pixel_overlay.sv
// Self-checking testbench of the speech mouth overlay: directed and random transfers
`timescale 1ns / 1ps

module tb_speech_mouth_pixel_overlay;
  import smpo_pkg::*;

  // Tracks the pose and timing state of the overlay and predicts the result of
  // every accepted input transfer; results are checked in arrival order.
  class overlay_tracker;
    cfg_t        regs;
    logic        active;
    logic [3:0]  target;
    logic [3:0]  shown;
    logic [47:0] voice_stamp;
    logic [47:0] step_stamp;
    out_item_t   awaited[$];
    int          errors;

    function new();
      regs             = '0;
      regs.white_color = 16'hFFFF;
      active           = 1'b0;
      target           = '0;
      shown            = '0;
      voice_stamp      = '0;
      step_stamp       = '0;
      errors           = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        REG_LEFT:     regs.mouth_left     = data[9:0];
        REG_TOP:      regs.mouth_top      = data[9:0];
        REG_RIGHT:    regs.mouth_right    = data[10:0];
        REG_BOTTOM:   regs.mouth_bottom   = data[10:0];
        REG_CENTER_X: regs.mouth_center_x = data[9:0];
        REG_CENTER_Y: regs.mouth_center_y = data[9:0];
        REG_BLACK:    regs.black_color    = data;
        REG_WHITE:    regs.white_color    = data;
        default: ;
      endcase
    endfunction

    // half width, depth and thickness of each pose; poses past four share the widest
    function bit on_arc(logic [9:0] x, logic [9:0] y, logic [3:0] pose);
      int hw, d, t, dx, base, off;
      case ((pose > 4'd4) ? 4'd4 : pose)
        4'd0:    begin hw = 10; d = 2; t = 2; end
        4'd1:    begin hw = 12; d = 3; t = 2; end
        4'd2:    begin hw = 14; d = 5; t = 3; end
        4'd3:    begin hw = 16; d = 7; t = 3; end
        default: begin hw = 18; d = 9; t = 4; end
      endcase
      dx = int'(x) - int'(regs.mouth_center_x);
      if (dx < -hw || dx > hw) return 1'b0;
      base = int'(regs.mouth_center_y) + d - (d * dx * dx) / (hw * hw);
      off  = int'(y) - base;
      return (off >= 0) && (off < t);
    endfunction

    function logic [15:0] overlay_pixel(logic [9:0] x, logic [9:0] y, logic [15:0] pix);
      logic [15:0] res;
      int          bright;
      res = pix;
      if (x >= regs.mouth_left && {1'b0, x} < regs.mouth_right &&
          y >= regs.mouth_top && {1'b0, y} < regs.mouth_bottom) begin
        bright = 2 * int'(pix[15:11]) + int'(pix[10:5]) + 2 * int'(pix[4:0]);
        if (bright >= int'(BRIGHT_MIN)) res = regs.black_color;
      end
      if (on_arc(x, y, shown)) res = regs.white_color;
      return res;
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t   want;
      logic [3:0]  req;
      logic [47:0] span;
      want.pixel_out = it.pixel_in;
      case (it.action)
        ACT_PIXEL: begin
          if (active) want.pixel_out = overlay_pixel(it.pixel_x, it.pixel_y, it.pixel_in);
        end
        ACT_LEVEL: begin
          if (active) begin
            req  = (it.level > 8'(POSE_MAX)) ? POSE_MAX : it.level[3:0];
            span = it.now_us - voice_stamp;
            if (req != 4'd0) begin
              voice_stamp = it.now_us;
              target      = req;
            end else if (span >= SILENCE_DELAY_US) begin
              target = 4'd0;
            end
          end
        end
        ACT_ACTIVE: begin
          active      = it.active_flag;
          target      = 4'd0;
          shown       = 4'd0;
          voice_stamp = it.active_flag ? it.now_us : 48'd0;
          step_stamp  = it.active_flag ? it.now_us : 48'd0;
        end
        default: begin
          span = it.now_us - step_stamp;
          if (active && span >= STEP_INTERVAL_US) begin
            if (shown < target) shown++;
            else if (shown > target) shown--;
            step_stamp = it.now_us;
          end
        end
      endcase
      want.shown_pose = shown;
      awaited.push_back(want);
    endfunction

    function void fault(string what, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= 10)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_transfer(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t ns: result %h with nothing awaited", $time, got);
        return;
      end
      want = awaited.pop_front();
      if (got.pixel_out !== want.pixel_out)
        fault("pixel_out", want.pixel_out, got.pixel_out);
      if (got.shown_pose !== want.shown_pose)
        fault("shown_pose", 16'(want.shown_pose), 16'(got.shown_pose));
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        errors += awaited.size();
        $display("%0d results never arrived", awaited.size());
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;
  logic      cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  overlay_tracker tracker = new();

  // running microsecond clock carried by the stimulus
  logic [47:0] wall_us;

  // sender burst shaping, changed per phase
  int burst_left = 0;
  int burst_max  = 16;
  int gap_max    = 3;

  // receiver stall pattern state
  int       stall_style = 0;
  int       stall_span  = 0;
  bit [3:0] stall_tick  = '0;

  speech_mouth_pixel_overlay u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Receiver: switch between no stall, random stall, a regular pattern and
  // long stall runs, each held for a random span, so gaps land on every pipeline phase.
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_span  <= $urandom_range(16, 96);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      2:       out_stall_i <= (stall_tick[1:0] == 2'd3);
      default: out_stall_i <= (stall_tick >= 4'd10);
    endcase
    stall_tick <= stall_tick + 4'd1;
  end

  // Check every output transfer against the oldest predicted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_transfer(out_item_o);
  end

  // Send one input transfer. Called at a falling edge and returns at one;
  // valid stays high between back-to-back calls and drops only for a gap.
  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    // hold the payload until the block takes it
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_transfer(it);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every predicted result to come back.
  task automatic drain();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (tracker.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Program the whole register set; only called while the block is idle.
  task automatic program_regs(input cfg_t c);
    write_reg(REG_LEFT, 16'(c.mouth_left));
    write_reg(REG_TOP, 16'(c.mouth_top));
    write_reg(REG_RIGHT, 16'(c.mouth_right));
    write_reg(REG_BOTTOM, 16'(c.mouth_bottom));
    write_reg(REG_CENTER_X, 16'(c.mouth_center_x));
    write_reg(REG_CENTER_Y, 16'(c.mouth_center_y));
    write_reg(REG_BLACK, c.black_color);
    write_reg(REG_WHITE, c.white_color);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Random item stamped with wall_us; callers override what the action needs.
  function automatic in_item_t filler(input act_e act);
    in_item_t it;
    it.action      = act;
    it.pixel_x     = 10'($urandom());
    it.pixel_y     = 10'($urandom());
    it.pixel_in    = 16'($urandom());
    it.level       = 8'($urandom());
    it.active_flag = 1'($urandom());
    it.now_us      = wall_us;
    return it;
  endfunction

  task automatic send_fields(input act_e act, input int x, input int y,
                             input logic [15:0] pix, input logic [7:0] lvl,
                             input logic flag, input logic [47:0] stamp);
    in_item_t it;
    it.action      = act;
    it.pixel_x     = 10'(x);
    it.pixel_y     = 10'(y);
    it.pixel_in    = pix;
    it.level       = lvl;
    it.active_flag = flag;
    it.now_us      = stamp;
    send(it);
  endtask

  // Directed walk: inactive passthrough, clamped level, stepping across the
  // time wrap, the brightness threshold, arc over erase, silence delay and
  // deactivation.
  task automatic directed_items();
    logic [47:0] t0;
    t0 = 48'hFFFF_FFFF_F000;
    send_fields(ACT_PIXEL, 1023, 1023, 16'hFFFF, 8'hFF, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_fields(ACT_LEVEL, 0, 0, 16'h0000, 8'd3, 1'b0, 48'd5);
    send_fields(ACT_FRAME, 0, 0, 16'h1234, 8'd0, 1'b0, 48'hFFFF_FFFF_FFFF);
    send_fields(ACT_ACTIVE, 0, 0, 16'h0000, 8'd0, 1'b1, t0);
    send_fields(ACT_LEVEL, 0, 0, 16'h0000, 8'd255, 1'b0, t0 + 48'd10);
    // one microsecond short of the step interval: no step
    send_fields(ACT_FRAME, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd39999);
    // exact interval, with the time counter wrapping past zero
    send_fields(ACT_FRAME, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd40000);
    send_fields(ACT_FRAME, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd80000);
    send_fields(ACT_FRAME, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd120000);
    send_fields(ACT_FRAME, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd160000);
    send_fields(ACT_PIXEL, 120, 113, 16'hFFFF, 8'd0, 1'b0, t0);
    send_fields(ACT_PIXEL, 101, 101, 16'h5000, 8'd0, 1'b0, t0);
    send_fields(ACT_PIXEL, 139, 115, 16'h4820, 8'd0, 1'b0, t0);
    send_fields(ACT_PIXEL, 100, 100, 16'h0000, 8'd0, 1'b0, t0);
    send_fields(ACT_PIXEL, 138, 104, 16'h0000, 8'd0, 1'b0, t0);
    send_fields(ACT_PIXEL, 140, 100, 16'hFFFF, 8'd0, 1'b0, t0);
    // zero level inside the silence delay, then exactly at it
    send_fields(ACT_LEVEL, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd160100);
    send_fields(ACT_LEVEL, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd200010);
    send_fields(ACT_FRAME, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd200000);
    send_fields(ACT_FRAME, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd240000);
    send_fields(ACT_ACTIVE, 0, 0, 16'h0000, 8'd0, 1'b0, t0 + 48'd250000);
    send_fields(ACT_PIXEL, 110, 110, 16'hFFFF, 8'd0, 1'b0, t0);
    send_fields(ACT_PIXEL, 0, 0, 16'h0000, 8'd0, 1'b0, 48'd0);
  endtask

  // Register set of each random phase: the extremes first, then random boxes.
  function automatic cfg_t layout_for(input int ph);
    cfg_t c;
    int   w, h;
    case (ph)
      0: begin
        c = '0;
        c.mouth_right  = 11'd1024;
        c.mouth_bottom = 11'd1024;
        c.white_color  = 16'hFFFF;
      end
      1: begin
        c.mouth_left     = 10'd1023;
        c.mouth_top      = 10'd1023;
        c.mouth_right    = 11'd1024;
        c.mouth_bottom   = 11'd1024;
        c.mouth_center_x = 10'd1023;
        c.mouth_center_y = 10'd1023;
        c.black_color    = 16'hFFFF;
        c.white_color    = 16'h0000;
      end
      2: begin
        // empty box: right left of left, bottom on top
        c.mouth_left     = 10'd500;
        c.mouth_top      = 10'd400;
        c.mouth_right    = 11'd300;
        c.mouth_bottom   = 11'd400;
        c.mouth_center_x = 10'd500;
        c.mouth_center_y = 10'd400;
        c.black_color    = 16'($urandom());
        c.white_color    = 16'($urandom());
      end
      default: begin
        w = $urandom_range(0, 60);
        h = $urandom_range(0, 30);
        c.mouth_left     = 10'($urandom_range(0, 1000));
        c.mouth_top      = 10'($urandom_range(0, 1000));
        c.mouth_right    = 11'((int'(c.mouth_left) + w > 1024) ? 1024
                                                               : int'(c.mouth_left) + w);
        c.mouth_bottom   = 11'((int'(c.mouth_top) + h > 1024) ? 1024
                                                              : int'(c.mouth_top) + h);
        c.mouth_center_x = 10'(int'(c.mouth_left) + w / 2);
        c.mouth_center_y = 10'(int'(c.mouth_top) + $urandom_range(0, 10));
        c.black_color    = 16'($urandom());
        c.white_color    = 16'($urandom());
        if ($urandom_range(0, 3) == 0) begin
          c.mouth_right  = 11'($urandom_range(0, 1024));
          c.mouth_bottom = 11'($urandom_range(0, 1024));
        end
      end
    endcase
    return c;
  endfunction

  // RGB565 value, often dim so the brightness threshold is hit from both sides.
  function automatic logic [15:0] source_pixel();
    if ($urandom_range(0, 99) < 40)
      return {5'($urandom_range(0, 12)), 6'($urandom_range(0, 20)),
              5'($urandom_range(0, 12))};
    return 16'($urandom());
  endfunction

  // One random phase: open with an activation, then mostly pixels around the
  // mouth mixed with level requests, frame starts, re-activations and noise.
  task automatic run_phase(input int count);
    in_item_t it;
    int       pick;
    cfg_t     c;
    c = tracker.regs;
    it = filler(ACT_ACTIVE);
    it.active_flag = 1'b1;
    send(it);
    for (int n = 1; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) wall_us = rand48();
        else if (pick == 1) wall_us = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 60000));
        it = filler(ACT_ACTIVE);
        it.active_flag = ($urandom_range(0, 3) != 0);
      end else if (pick < 13) begin
        wall_us += 48'($urandom_range(0, 30000));
        it = filler(ACT_LEVEL);
        pick = $urandom_range(0, 99);
        if (pick < 40) it.level = 8'd0;
        else if (pick < 85) it.level = 8'($urandom_range(1, 6));
      end else if (pick < 24) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) wall_us += 48'd40000;
        else if (pick == 1) wall_us += 48'd39999;
        else wall_us += 48'($urandom_range(0, 70000));
        it = filler(ACT_FRAME);
      end else if (pick < 29) begin
        // noise: every field random, the time stamp too
        it = filler(act_e'($urandom_range(0, 3)));
        it.now_us = rand48();
      end else begin
        wall_us += 48'($urandom_range(0, 2));
        it = filler(ACT_PIXEL);
        it.pixel_in = source_pixel();
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          it.pixel_x = 10'(int'(c.mouth_center_x) + $urandom_range(0, 40) - 20);
          it.pixel_y = 10'(int'(c.mouth_center_y) + $urandom_range(0, 14) - 1);
        end else if (pick < 85) begin
          it.pixel_x = 10'(int'(c.mouth_left) + $urandom_range(0, 42) - 2);
          it.pixel_y = 10'(int'(c.mouth_top) + $urandom_range(0, 26) - 2);
        end
      end
      send(it);
    end
  endtask

  initial begin
    cfg_t lay;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_LEFT;
    cfg_data_i  = '0;
    wall_us     = 48'd1000;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    lay = '0;
    lay.mouth_left     = 10'd100;
    lay.mouth_top      = 10'd100;
    lay.mouth_right    = 11'd140;
    lay.mouth_bottom   = 11'd116;
    lay.mouth_center_x = 10'd120;
    lay.mouth_center_y = 10'd104;
    lay.black_color    = 16'h0841;
    lay.white_color    = 16'hF81F;
    program_regs(lay);
    directed_items();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      program_regs(layout_for(ph));
      // one phase runs flat out, the rest vary burst and gap lengths
      burst_max = $urandom_range(1, 40);
      gap_max   = (ph == 3) ? 0 : $urandom_range(1, 6);
      run_phase(110);
    end

    drain();
    // allow for the pipeline depth before the final tally
    repeat (8) @(negedge clk_i);
    tracker.close_out();
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Timeout: far beyond the slowest legal run of this stimulus.
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/smpo_pkg.sv
sv/smpo_fifo.sv
sv/smpo_front.sv
sv/smpo_back.sv
sv/speech_mouth_pixel_overlay.sv
tb/tb_speech_mouth_pixel_overlay.sv
